### design/cpps_pkg.sv
// ---------------------------------------------------------------------------
// cpps_pkg: shared constants, types and the quarter-wave sine function
// Holds the sine entry function that fills the wave cells' quarter-wave tables.
// ---------------------------------------------------------------------------
package cpps_pkg;

    localparam int DEF_IMAGE_WIDTH     = 512;
    localparam int DEF_IMAGE_HEIGHT    = 512;
    localparam int DEF_PIXELS_PER_UNIT = 10;
    localparam int DEF_SINE_TABLE_BITS = 10;

    localparam int FREQ_W   = 16;
    localparam int COORD_W  = 9;
    localparam int LEVEL_W  = 8;
    localparam int SINE_W   = 16;   // signed Q2.14
    localparam int NUM_REGS = 6;
    localparam int ADDR_W   = 5;

    // register indexes
    localparam logic [2:0] REG_RED_N   = 3'd0;
    localparam logic [2:0] REG_RED_M   = 3'd1;
    localparam logic [2:0] REG_GREEN_N = 3'd2;
    localparam logic [2:0] REG_GREEN_M = 3'd3;
    localparam logic [2:0] REG_BLUE_N  = 3'd4;
    localparam logic [2:0] REG_BLUE_M  = 3'd5;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd4096;

    // one channel's frequency pair
    typedef struct packed {
        logic [FREQ_W-1:0] freq_n;
        logic [FREQ_W-1:0] freq_m;
    } freq_pair_t;

    // quarter-wave sine entry k of 2^bits, Q2.14, by truncated Taylor series
    function automatic logic [SINE_W-1:0] quarter_sine(input int k, input int bits);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] e;
        t = (64'(k) * 64'd1686629713) >> bits;
        t2 = (t * t) >> 30;
        term = t;
        sum = $signed(t);
        for (int i = 1; i <= 7; i++) begin
            term = ((term * t2) >> 30) / 64'((2 * i) * (2 * i + 1));
            if (i % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 0;
        e = (64'(sum) + 64'd32768) >> 16;
        if (e > 64'd16384)
            e = 64'd16384;
        return e[SINE_W-1:0];
    endfunction

endpackage

### design/cpps_wave_cell.sv
// ---------------------------------------------------------------------------
// cpps_wave_cell: one sine evaluation pipeline
// Registered phase product, reduction, index rounding and table lookup.
// Four cells per channel run side by side; each feeds the product registers.
// ---------------------------------------------------------------------------
module cpps_wave_cell #(
    parameter int PIXELS_PER_UNIT = 10,
    parameter int SINE_TABLE_BITS = 10,
    parameter int OFFS_W          = 13
) (
    input  logic                              clk,
    input  logic [cpps_pkg::FREQ_W-1:0]       freq,
    input  logic signed [OFFS_W-1:0]          offset,
    output logic signed [cpps_pkg::SINE_W-1:0] sine
);
    import cpps_pkg::*;

    // phase period is 8192 * PIXELS_PER_UNIT = 2^PH_SH * PIXELS_PER_UNIT
    localparam int     PH_SH  = 13;
    localparam int     DEN    = 8192 * PIXELS_PER_UNIT;
    localparam int     PROD_W = FREQ_W + OFFS_W + 1;
    localparam int     B      = SINE_TABLE_BITS;
    localparam int     IDX_W  = B + 2;
    localparam int     QLEN   = 1 << B;
    localparam int     DIV_L  = $clog2(PIXELS_PER_UNIT);
    localparam int     HI_W   = PROD_W - PH_SH;
    localparam int     AP_W   = HI_W + 1;
    localparam int     C_W    = DIV_L + 1;
    localparam int     PM_W   = C_W + PH_SH;
    localparam int     N2_W   = PM_W + IDX_W + 1;
    localparam int     X2_W   = DIV_L + B + 3;
    localparam int     M1_W   = AP_W + 2;
    localparam int     M2_W   = X2_W + 2;
    // multiple of PIXELS_PER_UNIT that lifts the upper phase bits above zero
    localparam longint A_OFF  = longint'(PIXELS_PER_UNIT)
                                * (((longint'(1) << (HI_W - 1)) + PIXELS_PER_UNIT - 1)
                                   / PIXELS_PER_UNIT);
    // reciprocals of PIXELS_PER_UNIT, rounded up, exact over the operand range
    localparam longint M1     = ((longint'(1) << (AP_W + DIV_L)) + PIXELS_PER_UNIT - 1)
                                / PIXELS_PER_UNIT;
    localparam longint M2     = ((longint'(1) << (X2_W + DIV_L)) + PIXELS_PER_UNIT - 1)
                                / PIXELS_PER_UNIT;

    logic signed [PROD_W-1:0] prod_reg;
    logic [PM_W-1:0]          pm_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [SINE_W-1:0] sine_reg;

    logic [SINE_W-1:0]        sine_rom [QLEN+1];

    logic [HI_W-1:0]          ph_hi;
    logic [AP_W-1:0]          ph_pos;
    logic [AP_W+M1_W-1:0]     q1_prod;
    logic [AP_W-1:0]          q1;
    logic [AP_W-1:0]          turn_rem;
    logic [PM_W-1:0]          pm;
    logic [N2_W-1:0]          num;
    logic [X2_W-1:0]          x2;
    logic [X2_W+M2_W-1:0]     q2_prod;
    logic [IDX_W-1:0]         idx;
    logic [B-1:0]             r;
    logic [B:0]               tab_idx;

    // quarter-wave table, constant contents
    initial
    begin
        for (int k = 0; k <= QLEN; k++)
            sine_rom[k] = quarter_sine(k, B);
    end

    // reduce phase into [0, DEN): low bits pass, upper part taken mod PIXELS_PER_UNIT
    always_comb
    begin
        ph_hi    = prod_reg[PROD_W-1:PH_SH];
        ph_pos   = AP_W'({ph_hi[HI_W-1], ph_hi}) + AP_W'(A_OFF);
        q1_prod  = (AP_W+M1_W)'(ph_pos) * (AP_W+M1_W)'(M1);
        q1       = AP_W'(q1_prod >> (AP_W + DIV_L));
        turn_rem = ph_pos - q1 * AP_W'(PIXELS_PER_UNIT);
        pm       = {turn_rem[C_W-1:0], prod_reg[PH_SH-1:0]};
    end

    // wave index, rounded half up, wrapped to one turn
    always_comb
    begin
        num     = (N2_W'(pm_reg) << IDX_W) + N2_W'(DEN / 2);
        x2      = X2_W'(num >> PH_SH);
        q2_prod = (X2_W+M2_W)'(x2) * (X2_W+M2_W)'(M2);
        idx     = IDX_W'(q2_prod >> (X2_W + DIV_L));
    end

    // quadrant fold
    always_comb
    begin
        r       = idx_reg[B-1:0];
        tab_idx = idx_reg[B] ? (B+1)'(QLEN) - {1'b0, r} : {1'b0, r};
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed({1'b0, freq}) * offset;
        pm_reg   <= pm;
        idx_reg  <= idx;
        sine_reg <= idx_reg[B+1] ? -$signed(sine_rom[tab_idx]) : $signed(sine_rom[tab_idx]);
    end

    assign sine = sine_reg;
endmodule

### design/cpps_channel.sv
// ---------------------------------------------------------------------------
// cpps_channel: one colour channel
// Four wave cells, registered products, difference, clamp and saturate.
// ---------------------------------------------------------------------------
module cpps_channel #(
    parameter int PIXELS_PER_UNIT = 10,
    parameter int SINE_TABLE_BITS = 10,
    parameter int OFFS_W          = 13
) (
    input  logic                               clk,
    input  cpps_pkg::freq_pair_t               freqs,
    input  logic signed [OFFS_W-1:0]           dx,
    input  logic signed [OFFS_W-1:0]           dy,
    output logic [cpps_pkg::LEVEL_W-1:0]       level
);
    import cpps_pkg::*;

    logic signed [SINE_W-1:0] s_nx, s_my, s_mx, s_ny;
    logic signed [2*SINE_W-1:0] p1_reg, p2_reg;
    logic signed [2*SINE_W:0]   d;
    logic [LEVEL_W-1:0]         level_reg;

    cpps_wave_cell #(.PIXELS_PER_UNIT(PIXELS_PER_UNIT), .SINE_TABLE_BITS(SINE_TABLE_BITS),
        .OFFS_W(OFFS_W)) u_nx (.clk(clk), .freq(freqs.freq_n), .offset(dx), .sine(s_nx));
    cpps_wave_cell #(.PIXELS_PER_UNIT(PIXELS_PER_UNIT), .SINE_TABLE_BITS(SINE_TABLE_BITS),
        .OFFS_W(OFFS_W)) u_my (.clk(clk), .freq(freqs.freq_m), .offset(dy), .sine(s_my));
    cpps_wave_cell #(.PIXELS_PER_UNIT(PIXELS_PER_UNIT), .SINE_TABLE_BITS(SINE_TABLE_BITS),
        .OFFS_W(OFFS_W)) u_mx (.clk(clk), .freq(freqs.freq_m), .offset(dx), .sine(s_mx));
    cpps_wave_cell #(.PIXELS_PER_UNIT(PIXELS_PER_UNIT), .SINE_TABLE_BITS(SINE_TABLE_BITS),
        .OFFS_W(OFFS_W)) u_ny (.clk(clk), .freq(freqs.freq_n), .offset(dy), .sine(s_ny));

    // difference of products, Q5.28
    assign d = (2*SINE_W+1)'(p1_reg) - (2*SINE_W+1)'(p2_reg);

    always_ff @(posedge clk)
    begin
        p1_reg <= s_nx * s_my;
        p2_reg <= s_mx * s_ny;
        if (d <= 0)
            level_reg <= '0;
        else if ((d >>> 21) > 255)
            level_reg <= '1;
        else
            level_reg <= LEVEL_W'(d >>> 21);
    end

    assign level = level_reg;
endmodule

### design/chladni_pattern_pixel_shader.sv
// ---------------------------------------------------------------------------
// chladni_pattern_pixel_shader: Chladni plate colour per pixel
// Top level with register file, coordinate centering and three channels.
// ---------------------------------------------------------------------------
// Usage: drive pixel_column/pixel_row with start high; busy is always low,
// so a new pixel is taken every cycle. Each pixel flows through a chain of
// registered stages: offset, phase product, reduction, index, sine lookup,
// products, level. done pulses for one cycle with red/green/blue_level
// as the pixel leaves the level stage. Throughput is one pixel per clock,
// set by the fully pipelined wave cells.
// Frequencies are written over the APB port at byte addresses 4*i; reset
// loads 1.0 (4096) into all six. Writes must be made only while idle; the
// block itself does not enforce this. Reset clears the valid chain; the
// receiver cannot stall and results are never held back.
// ---------------------------------------------------------------------------
module chladni_pattern_pixel_shader #(
    parameter int IMAGE_WIDTH     = cpps_pkg::DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT    = cpps_pkg::DEF_IMAGE_HEIGHT,
    parameter int PIXELS_PER_UNIT = cpps_pkg::DEF_PIXELS_PER_UNIT,
    parameter int SINE_TABLE_BITS = cpps_pkg::DEF_SINE_TABLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cpps_pkg::COORD_W-1:0]  pixel_column,
    input  logic [cpps_pkg::COORD_W-1:0]  pixel_row,
    output logic                          done,
    output logic [cpps_pkg::LEVEL_W-1:0]  red_level,
    output logic [cpps_pkg::LEVEL_W-1:0]  green_level,
    output logic [cpps_pkg::LEVEL_W-1:0]  blue_level,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpps_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import cpps_pkg::*;

    localparam int OFFS_W  = 14;
    localparam int LATENCY = 7;

    logic [FREQ_W-1:0] freq_reg [NUM_REGS];
    logic [LATENCY-1:0] valid_reg;
    logic signed [OFFS_W-1:0] dx_reg, dy_reg;
    logic [2:0] reg_idx;
    logic wr_en;
    freq_pair_t red_f, green_f, blue_f;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                freq_reg[i] <= FREQ_RESET;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            unique case (reg_idx) inside
                REG_RED_N, REG_RED_M, REG_GREEN_N, REG_GREEN_M, REG_BLUE_N, REG_BLUE_M:
                    freq_reg[reg_idx] <= pwdata[FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx < 3'(NUM_REGS) && paddr[1:0] == 2'b00)
            prdata = 32'(freq_reg[reg_idx]);
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[LATENCY-2:0], start};
    end

    // centered offsets
    always_ff @(posedge clk)
    begin
        dx_reg <= OFFS_W'(pixel_column) - OFFS_W'(IMAGE_WIDTH / 2);
        dy_reg <= OFFS_W'(pixel_row) - OFFS_W'(IMAGE_HEIGHT / 2);
    end

    assign red_f   = '{freq_n: freq_reg[REG_RED_N],   freq_m: freq_reg[REG_RED_M]};
    assign green_f = '{freq_n: freq_reg[REG_GREEN_N], freq_m: freq_reg[REG_GREEN_M]};
    assign blue_f  = '{freq_n: freq_reg[REG_BLUE_N],  freq_m: freq_reg[REG_BLUE_M]};

    cpps_channel #(.PIXELS_PER_UNIT(PIXELS_PER_UNIT), .SINE_TABLE_BITS(SINE_TABLE_BITS),
        .OFFS_W(OFFS_W)) u_red (.clk(clk), .freqs(red_f), .dx(dx_reg), .dy(dy_reg),
        .level(red_level));
    cpps_channel #(.PIXELS_PER_UNIT(PIXELS_PER_UNIT), .SINE_TABLE_BITS(SINE_TABLE_BITS),
        .OFFS_W(OFFS_W)) u_green (.clk(clk), .freqs(green_f), .dx(dx_reg), .dy(dy_reg),
        .level(green_level));
    cpps_channel #(.PIXELS_PER_UNIT(PIXELS_PER_UNIT), .SINE_TABLE_BITS(SINE_TABLE_BITS),
        .OFFS_W(OFFS_W)) u_blue (.clk(clk), .freqs(blue_f), .dx(dx_reg), .dy(dy_reg),
        .level(blue_level));

    assign done = valid_reg[LATENCY-1];

    // a result always follows a taken pixel through the valid chain
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done) else $error("result missing");
    // no result without a pixel taken
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY)) else $error("spurious result");
endmodule
